// ===== sv/bmo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmo_pkg: shared types and codes for the binary opening unit
// Holds the sequencer state type, register indexes and word codes.
// ----------------------------------------------------------------------------
package bmo_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 49;
  localparam int MASK_BITS = 49;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_COUNT = 3'd5;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [7:0] FG_LEVEL = 8'd255;
  localparam logic [7:0] BG_LEVEL = 8'd0;

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_COPY = 5'b00010,
    S_PASS = 5'b00100,
    S_GAP  = 5'b01000,
    S_READ = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== sv/binary_morph_open_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_morph_open_unit: frame store with morphological opening
// Loads a frame, runs erosion then dilation passes over bit planes held in
// on-chip memories, and reads the result back out in raster order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  in_     | sink      | in_valid/in_stall  | in_mode, in_pixel_in
//  out_    | source    | out_valid/out_stall| out_pixel_out, out_frame_end
//  cfg_    | sink      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Loads take one cycle per word while the output is not stalled. A readout
//  request passes the memory read register, then the output register.
//  After the last load the unit is busy with a threshold copy, then
//  2*pass_count passes over every element tap of every pixel (one element
//  tap per cycle, one read port per plane), with a gap state after the
//  copy and after each pass.
//  Reset is synchronous; the pixel memories are not cleared.
//  A stalled output holds its word and stalls the input behind it.
//
module binary_morph_open_unit
  import bmo_pkg::*;
#(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_ELEM = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [7:0]            in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_pixel_out,
  output logic                       out_frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = (PIX > 1) ? $clog2(PIX) : 1;
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int EW = $clog2(MAX_ELEM + 1);
  localparam int MW0 = (XW > YW) ? XW : YW;
  localparam int MW1 = (MW0 > EW) ? MW0 : EW;
  localparam int SW = MW1 + 2;
  localparam int TW = XW + YW;

  // configuration registers
  logic [8:0]  frame_width_r, frame_height_r;
  logic [2:0]  elem_width_r, elem_height_r;
  logic [MASK_BITS-1:0] elem_mask_r;
  logic [3:0]  pass_count_r;

  // control state
  state_t st_r, st_nxt;
  logic [AW-1:0] load_idx_r, load_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] cp_r, cp_nxt;
  logic          cp_v_r, cp_v_nxt;
  logic [AW-1:0] cp_addr_r;
  logic [XW-1:0] px_r, px_nxt;
  logic [YW-1:0] py_r, py_nxt;
  logic [EW-1:0] pr_r, pr_nxt, pc_r, pc_nxt;
  logic [AW-1:0] pix_r, pix_nxt;
  logic [4:0]    pass_r, pass_nxt;
  logic          in_a_r, in_a_nxt;
  logic          res_a_r, res_a_nxt;
  logic [XW-1:0] w_r, w_nxt;
  logic [YW-1:0] h_r, h_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_pix_r;
  logic          out_end_r;

  // tap pipeline stage
  logic          s1_v_r, s1_first_r, s1_last_r, s1_use_r, s1_out_r;
  logic          s1_erode_r, s1_src_a_r;
  logic [AW-1:0] s1_dst_r;
  logic          acc_r, acc_nxt;

  // memories
  logic [7:0] raw_mem [PIX];
  logic       plane_a_mem [PIX];
  logic       plane_b_mem [PIX];
  logic [7:0] raw_q;
  logic       a_q, b_q;
  logic          raw_we;
  logic [AW-1:0] raw_ra;
  logic          a_we, a_wd, b_we, b_wd;
  logic [AW-1:0] a_wa, a_ra, b_ra;

  // clamped geometry
  logic [XW-1:0] cur_w;
  logic [YW-1:0] cur_h;
  logic [TW-1:0] cur_total;
  logic [EW-1:0] cur_ew, cur_eh, ph, pw;
  logic [31:0]   fw32, fh32, ew32, eh32;

  logic in_take, out_take, load_last, rd_last, cp_last;
  logic erode, tap_last, pix_last, mbit, in_frame, s1_wr, s1_fg;
  logic [7:0] bidx;
  logic signed [SW-1:0] iy, ix;
  logic [TW-1:0] src_lin;
  logic [AW-1:0] src_addr;
  logic [4:0] two_n;

  assign fw32 = 32'(frame_width_r);
  assign fh32 = 32'(frame_height_r);
  assign ew32 = 32'(elem_width_r);
  assign eh32 = 32'(elem_height_r);

  always_comb begin
    cur_w = (fw32 == 32'd0) ? XW'(1) : (fw32 > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(fw32);
    cur_h = (fh32 == 32'd0) ? YW'(1) : (fh32 > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(fh32);
    cur_ew = (ew32 == 32'd0) ? EW'(1) : (ew32 > MAX_ELEM) ? EW'(MAX_ELEM) : EW'(ew32);
    cur_eh = (eh32 == 32'd0) ? EW'(1) : (eh32 > MAX_ELEM) ? EW'(MAX_ELEM) : EW'(eh32);
  end

  assign cur_total = TW'(cur_w) * TW'(cur_h);
  assign ph = cur_eh >> 1;
  assign pw = cur_ew >> 1;
  assign two_n = {pass_count_r, 1'b0};
  assign erode = (pass_r < {1'b0, pass_count_r});

  // handshakes
  assign in_stall = !((st_r == S_LOAD) || (st_r == S_READ)) || rd_pend_r ||
                    (out_valid_r && out_stall);
  assign in_take = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign cfg_ready = (st_r == S_LOAD) || (st_r == S_READ);

  assign out_valid = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_end_r;

  assign load_last = (32'(load_idx_r) + 32'd1) >= 32'(cur_total);
  assign rd_last = (32'(rd_idx_r) + 32'd1) >= 32'(total_r);
  assign cp_last = (32'(cp_r) + 32'd1) >= 32'(total_r);

  // element tap for the current issue slot
  assign bidx = 8'(pr_r) * 8'(MAX_ELEM) + 8'(pc_r);
  assign mbit = (bidx < 8'(MASK_BITS)) ? elem_mask_r[bidx[5:0]] : 1'b0;
  assign iy = $signed(SW'(py_r)) + $signed(SW'(pr_r)) - $signed(SW'(ph));
  assign ix = $signed(SW'(px_r)) + $signed(SW'(pc_r)) - $signed(SW'(pw));
  assign in_frame = (iy >= 0) && (iy < $signed(SW'(h_r))) &&
                    (ix >= 0) && (ix < $signed(SW'(w_r)));
  assign src_lin = TW'(iy[YW-1:0]) * TW'(w_r) + TW'(ix[XW-1:0]);
  assign src_addr = in_frame ? AW'(src_lin) : '0;
  assign tap_last = (pr_r == cur_eh - EW'(1)) && (pc_r == cur_ew - EW'(1));
  assign pix_last = (px_r == w_r - XW'(1)) && (py_r == h_r - YW'(1));

  // fold one tap into the running result
  always_comb begin
    logic base;
    base = s1_first_r ? s1_erode_r : acc_r;
    s1_fg = s1_src_a_r ? a_q : b_q;
    acc_nxt = base;
    if (s1_use_r) begin
      acc_nxt = s1_erode_r ? (base & s1_fg) : (base | s1_fg);
    end else if (s1_out_r && s1_erode_r) begin
      acc_nxt = 1'b0;
    end
  end
  assign s1_wr = s1_v_r && s1_last_r;

  // memory port steering
  assign raw_we = in_take && (st_r == S_LOAD) && (in_mode == MODE_LOAD);
  assign raw_ra = (st_r == S_COPY) ? cp_r : rd_idx_r;
  assign a_ra = (st_r == S_PASS) ? src_addr : rd_idx_r;
  assign b_ra = a_ra;
  assign a_we = cp_v_r || (s1_wr && !s1_src_a_r);
  assign a_wa = cp_v_r ? cp_addr_r : s1_dst_r;
  assign a_wd = cp_v_r ? (raw_q == FG_LEVEL) : acc_nxt;
  assign b_we = s1_wr && s1_src_a_r;
  assign b_wd = acc_nxt;

  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[load_idx_r] <= in_pixel_in;
    end
    raw_q <= raw_mem[raw_ra];
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      plane_a_mem[a_wa] <= a_wd;
    end
    a_q <= plane_a_mem[a_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      plane_b_mem[s1_dst_r] <= b_wd;
    end
    b_q <= plane_b_mem[b_ra];
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    load_idx_nxt = load_idx_r;
    rd_idx_nxt = rd_idx_r;
    cp_nxt = cp_r;
    cp_v_nxt = 1'b0;
    px_nxt = px_r;
    py_nxt = py_r;
    pr_nxt = pr_r;
    pc_nxt = pc_r;
    pix_nxt = pix_r;
    pass_nxt = pass_r;
    in_a_nxt = in_a_r;
    res_a_nxt = res_a_r;
    w_nxt = w_r;
    h_nxt = h_r;
    total_nxt = total_r;
    rd_pend_nxt = 1'b0;
    rd_last_nxt = rd_last_r;
    case (st_r)
      S_LOAD: begin
        // drop read requests while loading
        if (in_take && (in_mode == MODE_LOAD)) begin
          if (load_last) begin
            st_nxt = S_COPY;
            load_idx_nxt = '0;
            w_nxt = cur_w;
            h_nxt = cur_h;
            total_nxt = cur_total;
            cp_nxt = '0;
          end else begin
            load_idx_nxt = load_idx_r + AW'(1);
          end
        end
      end
      S_COPY: begin
        cp_v_nxt = 1'b1;
        if (cp_last) begin
          st_nxt = S_GAP;
          pass_nxt = '0;
          in_a_nxt = 1'b1;
        end else begin
          cp_nxt = cp_r + AW'(1);
        end
      end
      S_PASS: begin
        if (tap_last) begin
          pr_nxt = '0;
          pc_nxt = '0;
          pix_nxt = pix_r + AW'(1);
          if (pix_last) begin
            st_nxt = S_GAP;
            pass_nxt = pass_r + 5'd1;
            in_a_nxt = !in_a_r;
          end else if (px_r == w_r - XW'(1)) begin
            px_nxt = '0;
            py_nxt = py_r + YW'(1);
          end else begin
            px_nxt = px_r + XW'(1);
          end
        end else if (pc_r == cur_ew - EW'(1)) begin
          pc_nxt = '0;
          pr_nxt = pr_r + EW'(1);
        end else begin
          pc_nxt = pc_r + EW'(1);
        end
      end
      S_GAP: begin
        // let the last write land before the next pass reads it
        px_nxt = '0;
        py_nxt = '0;
        pr_nxt = '0;
        pc_nxt = '0;
        pix_nxt = '0;
        if (pass_r < two_n) begin
          st_nxt = S_PASS;
        end else begin
          st_nxt = S_READ;
          res_a_nxt = in_a_r;
          rd_idx_nxt = '0;
        end
      end
      S_READ: begin
        // drop loads while reading out
        if (in_take && (in_mode == MODE_READ)) begin
          rd_pend_nxt = 1'b1;
          rd_last_nxt = rd_last;
          if (rd_last) begin
            st_nxt = S_LOAD;
            rd_idx_nxt = '0;
            load_idx_nxt = '0;
          end else begin
            rd_idx_nxt = rd_idx_r + AW'(1);
          end
        end
      end
      default: begin
        st_nxt = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = 1'b0;
    end
    if (rd_pend_r) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= 9'd256;
      frame_height_r <= 9'd256;
      elem_width_r <= 3'd3;
      elem_height_r <= 3'd3;
      elem_mask_r <= 49'd115591;
      pass_count_r <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: frame_width_r <= cfg_data[8:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[8:0];
        CFG_ELEM_WIDTH: elem_width_r <= cfg_data[2:0];
        CFG_ELEM_HEIGHT: elem_height_r <= cfg_data[2:0];
        CFG_ELEM_MASK: elem_mask_r <= cfg_data[MASK_BITS-1:0];
        CFG_PASS_COUNT: pass_count_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
      load_idx_r <= '0;
      rd_idx_r <= '0;
      cp_r <= '0;
      cp_v_r <= 1'b0;
      px_r <= '0;
      py_r <= '0;
      pr_r <= '0;
      pc_r <= '0;
      pix_r <= '0;
      pass_r <= '0;
      in_a_r <= 1'b1;
      res_a_r <= 1'b1;
      w_r <= XW'(1);
      h_r <= YW'(1);
      total_r <= TW'(1);
      rd_pend_r <= 1'b0;
      rd_last_r <= 1'b0;
      out_valid_r <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      load_idx_r <= load_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cp_r <= cp_nxt;
      cp_v_r <= cp_v_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      pr_r <= pr_nxt;
      pc_r <= pc_nxt;
      pix_r <= pix_nxt;
      pass_r <= pass_nxt;
      in_a_r <= in_a_nxt;
      res_a_r <= res_a_nxt;
      w_r <= w_nxt;
      h_r <= h_nxt;
      total_r <= total_nxt;
      rd_pend_r <= rd_pend_nxt;
      rd_last_r <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r <= (st_r == S_PASS);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cp_addr_r <= cp_r;
    s1_first_r <= (pr_r == '0) && (pc_r == '0);
    s1_last_r <= tap_last;
    s1_use_r <= mbit && in_frame;
    s1_out_r <= mbit && !in_frame;
    s1_erode_r <= erode;
    s1_src_a_r <= in_a_r;
    s1_dst_r <= pix_r;
    if (s1_v_r) begin
      acc_r <= acc_nxt;
    end
    if (rd_pend_r) begin
      out_end_r <= rd_last_r;
      if (pass_count_r == 4'd0) begin
        out_pix_r <= raw_q;
      end else begin
        out_pix_r <= (res_a_r ? a_q : b_q) ? FG_LEVEL : BG_LEVEL;
      end
    end
  end

  // busy states take no words and no register writes
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == S_COPY) || (st_r == S_PASS) || (st_r == S_GAP)) |-> (in_stall && !cfg_ready))
    else $error("word or register write taken while processing");

  // a returning read always finds the output register free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r)
    else $error("readout overran the output register");

  // copy and pass writes never share the plane port
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cp_v_r && s1_v_r))
    else $error("copy and pass collide on plane write");

  // a pending read makes the output word valid in the next cycle
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid_r)
    else $error("readout word lost");

endmodule
`default_nettype wire
